@@ rtl/core/ivpa_pkg.sv @@
package ivpa_pkg;

  // Fixed field widths of the block's ports.
  localparam int unsigned MASK_W = 16;
  localparam int unsigned VEC_W  = 12;
  localparam int unsigned CPU_W  = 4;
  localparam int unsigned REFS_W = 8;
  localparam int unsigned LOAD_W = 7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [REFS_W-1:0] REFS_MAX = 8'd255;
  localparam logic [LOAD_W-1:0] LOAD_MAX = 7'd127;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_GET   = 2'd1,
    REQ_PUT   = 2'd2
  } req_type_e;

  typedef enum logic [3:0] {
    RS_SHARED      = 4'd0,
    RS_NEW         = 4'd1,
    RS_SHARED_EXH  = 4'd2,
    RS_EXHAUSTED   = 4'd3,
    RS_GOT         = 4'd4,
    RS_GET_REFUSED = 4'd5,
    RS_DROPPED     = 4'd6,
    RS_FREED       = 4'd7,
    RS_BAD_PUT     = 4'd8,
    RS_EMPTY_MASK  = 4'd9
  } status_e;

  typedef enum logic [2:0] {
    CFG_ONLINE    = 3'd0,
    CFG_POOL_BASE = 3'd1,
    CFG_POOL_SIZE = 3'd2,
    CFG_MIN_REFS  = 3'd3,
    CFG_MAX_REFS  = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_REQ,
    S_SCAN,
    S_DECIDE,
    S_CPU_SCAN,
    S_CPU_PICK,
    S_ALLOC,
    S_SHARE,
    S_EMPTY,
    S_EXHAUST,
    S_LOOKUP,
    S_REF
  } state_e;

  // Datapath operation issued by the controller each cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_SCAN_START,
    OP_SCAN,
    OP_DECIDE,
    OP_CPU_SCAN,
    OP_CPU_PICK,
    OP_ALLOC,
    OP_SHARE,
    OP_REF,
    OP_EMPTY,
    OP_EXHAUST
  } dp_op_e;

  typedef struct packed {
    logic mask_zero;
    logic n_zero;
    logic scan_hit;
    logic scan_last;
    logic free_found;
    logic best_found;
    logic onehot;
    logic cpu_hit;
    logic cpu_last;
    logic out_free;
  } dp_sts_t;

  typedef struct packed {
    logic [REFS_W-1:0] refs;
    logic [CPU_W-1:0]  cpu;
  } slot_t;

  // Index of the lowest set bit, zero when no bit is set.
  function automatic logic [CPU_W-1:0] lowest_bit(input logic [MASK_W-1:0] m);
    logic [CPU_W-1:0] r;
    r = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (m[i]) begin
        r = CPU_W'(i);
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/core/ivpa_ctrl.sv @@
module ivpa_ctrl import ivpa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic [1:0]  req_type_i,
  input  dp_sts_t     sts_i,
  output logic        in_stall_o,
  output dp_op_e      op_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    op_o       = OP_NONE;
    in_stall_o = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_o = OP_LATCH;
          unique case (req_type_i)
            REQ_ALLOC:        state_d = S_REQ;
            REQ_GET, REQ_PUT: state_d = S_LOOKUP;
            default:          state_d = S_IDLE;
          endcase
        end
      end
      S_REQ: begin
        op_o = OP_SCAN_START;
        priority if (sts_i.mask_zero) begin
          state_d = S_EMPTY;
        end else if (sts_i.n_zero) begin
          state_d = S_DECIDE;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        op_o = OP_SCAN;
        priority if (sts_i.scan_hit) begin
          state_d = S_SHARE;
        end else if (sts_i.scan_last) begin
          state_d = S_DECIDE;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_DECIDE: begin
        op_o = OP_DECIDE;
        priority if (sts_i.free_found) begin
          state_d = sts_i.onehot ? S_ALLOC : S_CPU_SCAN;
        end else if (sts_i.best_found) begin
          state_d = S_SHARE;
        end else begin
          state_d = S_EXHAUST;
        end
      end
      S_CPU_SCAN: begin
        op_o = OP_CPU_SCAN;
        priority if (sts_i.cpu_hit) begin
          state_d = S_ALLOC;
        end else if (sts_i.cpu_last) begin
          state_d = S_CPU_PICK;
        end else begin
          state_d = S_CPU_SCAN;
        end
      end
      S_CPU_PICK: begin
        op_o    = OP_CPU_PICK;
        state_d = S_ALLOC;
      end
      S_LOOKUP: begin
        state_d = S_REF;
      end
      S_ALLOC: begin
        if (sts_i.out_free) begin
          op_o    = OP_ALLOC;
          state_d = S_IDLE;
        end
      end
      S_SHARE: begin
        if (sts_i.out_free) begin
          op_o    = OP_SHARE;
          state_d = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (sts_i.out_free) begin
          op_o    = OP_EMPTY;
          state_d = S_IDLE;
        end
      end
      S_EXHAUST: begin
        if (sts_i.out_free) begin
          op_o    = OP_EXHAUST;
          state_d = S_IDLE;
        end
      end
      S_REF: begin
        if (sts_i.out_free) begin
          op_o    = OP_REF;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/ivpa_dpath.sv @@
module ivpa_dpath import ivpa_pkg::*; #(
  parameter int POOL_DEPTH = 64,
  parameter int NUM_CPUS   = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dp_op_e                op_i,
  output dp_sts_t               sts_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic [1:0]            req_type_i,
  input  logic [MASK_W-1:0]     cpu_sel_i,
  input  logic [VEC_W-1:0]      vector_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [3:0]            status_o,
  output logic [VEC_W-1:0]      result_vector_o,
  output logic [CPU_W-1:0]      bound_cpu_o,
  output logic [REFS_W-1:0]     ref_count_o,
  output logic                  overloaded_o
);

  localparam int IW   = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CW   = (IW > CPU_W) ? IW : CPU_W;
  localparam int NCPU = (NUM_CPUS < 16) ? NUM_CPUS : 16;
  localparam int CPW  = (NCPU > 1) ? $clog2(NCPU) : 1;
  localparam logic [MASK_W-1:0] FIELD_MASK =
    (NUM_CPUS >= 16) ? 16'hFFFF : MASK_W'((32'd1 << NUM_CPUS) - 32'd1);
  localparam logic [8:0] DEPTH_N = 9'(POOL_DEPTH);

  // Configuration registers.
  logic [MASK_W-1:0] online_q;
  logic [10:0]       base_q;
  logic [6:0]        size_q;
  logic [REFS_W-1:0] min_q;
  logic [REFS_W-1:0] max_q;

  // Latched item.
  logic [1:0]        type_q;
  logic [MASK_W-1:0] mask_q;
  logic [VEC_W-1:0]  vec_q;

  // Pool state.
  logic [POOL_DEPTH-1:0] valid_q;
  slot_t                 mem_q [POOL_DEPTH];
  slot_t                 rdata_q;
  logic [LOAD_W-1:0]     load_q [NCPU];

  // Scan trackers.
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              free_found_q, best_found_q, cb_found_q;
  logic [IW-1:0]     free_idx_q, best_idx_q, tgt_idx_q;
  slot_t             best_q, tgt_q;
  status_e           tgt_st_q;
  logic [CPU_W-1:0]  chosen_q, cb_q;
  logic [LOAD_W-1:0] cb_load_q;

  // Output register.
  logic              out_valid_q;
  status_e           out_st_q, out_st_d;
  logic [VEC_W-1:0]  out_vec_q, out_vec_d;
  logic [CPU_W-1:0]  out_cpu_q, out_cpu_d;
  logic [REFS_W-1:0] out_refs_q, out_refs_d;
  logic              out_ovl_q, out_ovl_d;
  logic              commit;

  logic [8:0]        n_eff;
  logic [VEC_W-1:0]  off;
  logic [IW-1:0]     off_idx, slot_idx, raddr;
  logic              in_range;
  logic              match, hit, best_upd;
  logic [CPU_W-1:0]  cpu_idx, la;
  logic [LOAD_W-1:0] load_rd, load_wdata;
  logic              load_we;
  logic              cand, cpu_hit, cb_upd;
  logic [REFS_W-1:0] share_refs, get_refs;
  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  slot_t             mem_wdata;
  logic              valid_set, valid_clr;
  logic              out_free;

  function automatic logic [REFS_W-1:0] sat_inc(input logic [REFS_W-1:0] v);
    return (v == REFS_MAX) ? v : v + 8'd1;
  endfunction

  assign n_eff    = ({2'b00, size_q} < DEPTH_N) ? {2'b00, size_q} : DEPTH_N;
  assign off      = vec_q - {1'b0, base_q};
  assign off_idx  = off[IW-1:0];
  assign in_range = (vec_q >= {1'b0, base_q}) && ({3'b000, n_eff} > off) && valid_q[off_idx];
  assign slot_idx = cnt_q[IW-1:0];
  assign cpu_idx  = cnt_q[CPU_W-1:0];
  assign out_free = !out_valid_q || !out_stall_i;

  // Slot scan: one slot per cycle, read address runs one ahead of the count.
  assign match    = valid_q[slot_idx] && mask_q[rdata_q.cpu];
  assign hit      = (op_i == OP_SCAN) && match && (rdata_q.refs < min_q);
  assign best_upd = match && (!best_found_q || (rdata_q.refs < best_q.refs));

  // CPU scan over the load counters.
  assign load_rd = load_q[la[CPW-1:0]];
  assign cand    = mask_q[cpu_idx] && online_q[cpu_idx];
  assign cpu_hit = (op_i == OP_CPU_SCAN) && cand && (load_rd == '0);
  assign cb_upd  = cand && (!cb_found_q || (load_rd < cb_load_q));

  assign share_refs = sat_inc(tgt_q.refs);
  assign get_refs   = sat_inc(rdata_q.refs);

  always_comb begin
    sts_o.mask_zero  = (mask_q == '0);
    sts_o.n_zero     = (n_eff == '0);
    sts_o.scan_hit   = hit;
    sts_o.scan_last  = (9'(cnt_q) == (n_eff - 9'd1));
    sts_o.free_found = free_found_q;
    sts_o.best_found = best_found_q;
    sts_o.onehot     = ((mask_q & (mask_q - 16'd1)) == '0);
    sts_o.cpu_hit    = cpu_hit;
    sts_o.cpu_last   = (cnt_q == CW'(NCPU - 1));
    sts_o.out_free   = out_free;
  end

  always_comb begin
    cnt_d = cnt_q;
    raddr = off_idx;
    unique case (op_i)
      OP_SCAN_START, OP_DECIDE: cnt_d = '0;
      OP_SCAN, OP_CPU_SCAN:     cnt_d = cnt_q + CW'(1);
      default:                  cnt_d = cnt_q;
    endcase
    if (op_i == OP_SCAN_START || op_i == OP_SCAN) begin
      raddr = cnt_d[IW-1:0];
    end
  end

  always_comb begin
    unique case (op_i)
      OP_CPU_SCAN: la = cpu_idx;
      OP_REF:      la = rdata_q.cpu;
      default:     la = chosen_q;
    endcase
  end

  // Commit: result beat plus the state update of one item.
  always_comb begin
    commit     = 1'b0;
    out_st_d   = RS_EMPTY_MASK;
    out_vec_d  = '0;
    out_cpu_d  = '0;
    out_refs_d = '0;
    out_ovl_d  = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = off_idx;
    mem_wdata  = rdata_q;
    valid_set  = 1'b0;
    valid_clr  = 1'b0;
    load_we    = 1'b0;
    load_wdata = load_rd;
    unique case (op_i)
      OP_ALLOC: begin
        commit         = 1'b1;
        out_st_d       = RS_NEW;
        out_vec_d      = VEC_W'({1'b0, base_q}) + VEC_W'(free_idx_q);
        out_cpu_d      = chosen_q;
        out_refs_d     = 8'd1;
        mem_we         = 1'b1;
        mem_waddr      = free_idx_q;
        mem_wdata.refs = 8'd1;
        mem_wdata.cpu  = chosen_q;
        valid_set      = 1'b1;
        load_we        = 1'b1;
        load_wdata     = (load_rd < LOAD_MAX) ? load_rd + 7'd1 : load_rd;
      end
      OP_SHARE: begin
        commit         = 1'b1;
        out_st_d       = tgt_st_q;
        out_vec_d      = VEC_W'({1'b0, base_q}) + VEC_W'(tgt_idx_q);
        out_cpu_d      = tgt_q.cpu;
        out_refs_d     = share_refs;
        out_ovl_d      = (share_refs > max_q);
        mem_we         = 1'b1;
        mem_waddr      = tgt_idx_q;
        mem_wdata.refs = share_refs;
        mem_wdata.cpu  = tgt_q.cpu;
      end
      OP_REF: begin
        commit    = 1'b1;
        out_vec_d = vec_q;
        if (type_q == REQ_GET) begin
          if (in_range) begin
            out_st_d       = RS_GOT;
            out_cpu_d      = rdata_q.cpu;
            out_refs_d     = get_refs;
            mem_we         = 1'b1;
            mem_wdata.refs = get_refs;
          end else begin
            out_st_d = RS_GET_REFUSED;
          end
        end else begin
          priority if (!in_range) begin
            out_st_d = RS_BAD_PUT;
          end else if (rdata_q.refs > 8'd1) begin
            out_st_d       = RS_DROPPED;
            out_cpu_d      = rdata_q.cpu;
            out_refs_d     = rdata_q.refs - 8'd1;
            mem_we         = 1'b1;
            mem_wdata.refs = rdata_q.refs - 8'd1;
          end else begin
            // Last reference gone: the slot is freed and its CPU unloaded.
            out_st_d       = RS_FREED;
            out_cpu_d      = rdata_q.cpu;
            mem_we         = 1'b1;
            mem_wdata.refs = '0;
            valid_clr      = 1'b1;
            load_we        = 1'b1;
            load_wdata     = (load_rd != '0) ? load_rd - 7'd1 : load_rd;
          end
        end
      end
      OP_EMPTY: begin
        commit   = 1'b1;
        out_st_d = RS_EMPTY_MASK;
      end
      OP_EXHAUST: begin
        commit   = 1'b1;
        out_st_d = RS_EXHAUSTED;
      end
      default: begin
        commit = 1'b0;
      end
    endcase
  end

  // Control state and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      online_q     <= 16'hFFFF;
      base_q       <= '0;
      size_q       <= 7'd64;
      min_q        <= 8'd2;
      max_q        <= 8'd16;
      valid_q      <= '0;
      out_valid_q  <= 1'b0;
      free_found_q <= 1'b0;
      best_found_q <= 1'b0;
      cb_found_q   <= 1'b0;
      for (int i = 0; i < NCPU; i++) begin
        load_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_ONLINE:    online_q <= cfg_wdata_i;
          CFG_POOL_BASE: base_q   <= cfg_wdata_i[10:0];
          CFG_POOL_SIZE: size_q   <= cfg_wdata_i[6:0];
          CFG_MIN_REFS:  min_q    <= cfg_wdata_i[7:0];
          CFG_MAX_REFS:  max_q    <= cfg_wdata_i[7:0];
          default:       ;
        endcase
      end
      if (valid_set) begin
        valid_q[free_idx_q] <= 1'b1;
      end
      if (valid_clr) begin
        valid_q[off_idx] <= 1'b0;
      end
      if (load_we) begin
        load_q[la[CPW-1:0]] <= load_wdata;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (op_i)
        OP_SCAN_START: begin
          free_found_q <= 1'b0;
          best_found_q <= 1'b0;
        end
        OP_SCAN: begin
          if (!valid_q[slot_idx] && !free_found_q) begin
            free_found_q <= 1'b1;
          end
          if (!hit && best_upd) begin
            best_found_q <= 1'b1;
          end
        end
        OP_DECIDE: begin
          cb_found_q <= 1'b0;
        end
        OP_CPU_SCAN: begin
          if (!cpu_hit && cb_upd) begin
            cb_found_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    if (op_i == OP_LATCH) begin
      type_q <= req_type_i;
      mask_q <= cpu_sel_i & FIELD_MASK;
      vec_q  <= vector_i;
    end
    unique case (op_i)
      OP_SCAN: begin
        if (!valid_q[slot_idx] && !free_found_q) begin
          free_idx_q <= slot_idx;
        end
        if (hit) begin
          tgt_idx_q <= slot_idx;
          tgt_q     <= rdata_q;
          tgt_st_q  <= RS_SHARED;
        end else if (best_upd) begin
          best_idx_q <= slot_idx;
          best_q     <= rdata_q;
        end
      end
      OP_DECIDE: begin
        // The best match is only used when the pool turns out full.
        tgt_idx_q <= best_idx_q;
        tgt_q     <= best_q;
        tgt_st_q  <= RS_SHARED_EXH;
        chosen_q  <= lowest_bit(mask_q);
      end
      OP_CPU_SCAN: begin
        if (cpu_hit) begin
          chosen_q <= cpu_idx;
        end else if (cb_upd) begin
          cb_q      <= cpu_idx;
          cb_load_q <= load_rd;
        end
      end
      OP_CPU_PICK: begin
        chosen_q <= cb_found_q ? cb_q : lowest_bit(online_q & FIELD_MASK);
      end
      default: ;
    endcase
    if (commit) begin
      out_st_q   <= out_st_d;
      out_vec_q  <= out_vec_d;
      out_cpu_q  <= out_cpu_d;
      out_refs_q <= out_refs_d;
      out_ovl_q  <= out_ovl_d;
    end
  end

  // Slot memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_st_q;
  assign result_vector_o = out_vec_q;
  assign bound_cpu_o     = out_cpu_q;
  assign ref_count_o     = out_refs_q;
  assign overloaded_o    = out_ovl_q;

endmodule

@@ rtl/core/irq_vector_pool_allocator.sv @@
// Interrupt vector pool allocator. Each pool slot stands for vector pool_base + slot, is bound
// to one CPU and carries a saturating reference count. A request beat (req_type 0) scans the
// valid slots whose CPU lies in cpu_sel: the first one with a count below min_refs is shared
// (status shared); otherwise the lowest free slot is allocated and bound to the mask's single
// CPU or to the least-loaded online CPU of the mask (status new); with a full pool the matching
// slot with the lowest count is shared (status shared exhausted), and overloaded flags a shared
// count above max_refs. Take (1) and drop (2) beats adjust the count of the addressed vector;
// the last drop frees the slot and lowers its CPU's load. Type 3 gives no result. The block
// works on one beat at a time; a request is paced by the slot scan, which reads the slot
// memory one entry per cycle over the effective pool size, then by a scan of the CPU load
// counters when a multi-CPU mask needs a new slot. A new beat is accepted while the previous
// result still waits in the output register. The user must write configuration through the
// plain write port only while the block is idle; the block itself does not enforce this.
module irq_vector_pool_allocator import ivpa_pkg::*; #(
  parameter int POOL_DEPTH = 64,
  parameter int NUM_CPUS   = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            req_type_i,
  input  logic [MASK_W-1:0]     cpu_sel_i,
  input  logic [VEC_W-1:0]      vector_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [3:0]            status_o,
  output logic [VEC_W-1:0]      result_vector_o,
  output logic [CPU_W-1:0]      bound_cpu_o,
  output logic [REFS_W-1:0]     ref_count_o,
  output logic                  overloaded_o
);

  // The controller sequences each beat; the datapath holds the pool, the CPU
  // loads, the configuration and the output register.
  dp_op_e  op;
  dp_sts_t sts;

  ivpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .op_o       (op)
  );

  ivpa_dpath #(
    .POOL_DEPTH (POOL_DEPTH),
    .NUM_CPUS   (NUM_CPUS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (op),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .req_type_i      (req_type_i),
    .cpu_sel_i       (cpu_sel_i),
    .vector_i        (vector_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .result_vector_o (result_vector_o),
    .bound_cpu_o     (bound_cpu_o),
    .ref_count_o     (ref_count_o),
    .overloaded_o    (overloaded_o)
  );

endmodule

@@ tb/sv/ivpa_tb_pkg.sv @@
package ivpa_tb_pkg;

  import ivpa_pkg::*;

  localparam int SLOTS = 64;
  localparam int CPUS  = 16;

  // The fourth request code has no meaning: the block drops such a beat.
  localparam logic [1:0] REQ_IGNORED = 2'd3;

  typedef struct packed {
    status_e           status;
    logic [VEC_W-1:0]  vec;
    logic [CPU_W-1:0]  cpu;
    logic [REFS_W-1:0] refs;
    logic              ovl;
  } grant_t;

  // Mirrors the pool and the CPU loads, and holds the grants still owed by the block.
  class grant_tracker;
    logic              in_use [SLOTS];
    logic [REFS_W-1:0] count  [SLOTS];
    logic [CPU_W-1:0]  owner  [SLOTS];
    logic [LOAD_W-1:0] load   [CPUS];

    logic [MASK_W-1:0] cpus_up;
    logic [10:0]       base_vec;
    logic [6:0]        slots_cfg;
    logic [7:0]        share_below;
    logic [7:0]        overload_above;

    grant_t due_grants[$];
    int     errors;

    function new();
      for (int s = 0; s < SLOTS; s++) begin
        in_use[s] = 1'b0;
        count[s]  = '0;
        owner[s]  = '0;
      end
      for (int c = 0; c < CPUS; c++) begin
        load[c] = '0;
      end
      cpus_up        = 16'hFFFF;
      base_vec       = '0;
      slots_cfg      = 7'd64;
      share_below    = 8'd2;
      overload_above = 8'd16;
      errors         = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_ONLINE:    cpus_up        = val;
        CFG_POOL_BASE: base_vec       = val[10:0];
        CFG_POOL_SIZE: slots_cfg      = val[6:0];
        CFG_MIN_REFS:  share_below    = val[7:0];
        CFG_MAX_REFS:  overload_above = val[7:0];
        default: ;
      endcase
    endfunction

    function int span();
      return (slots_cfg < SLOTS) ? int'(slots_cfg) : SLOTS;
    endfunction

    function int pending();
      return due_grants.size();
    endfunction

    function grant_t make(status_e st, int vec, int cpu, int cnt, bit ovl);
      grant_t g;
      g.status = st;
      g.vec    = VEC_W'(vec);
      g.cpu    = CPU_W'(cpu);
      g.refs   = REFS_W'(cnt);
      g.ovl    = ovl;
      return g;
    endfunction

    // A single-CPU mask binds to that CPU; otherwise the first idle online CPU of the
    // mask, then the least loaded one, then the lowest online CPU at all.
    function int pick_cpu(logic [MASK_W-1:0] m);
      logic [MASK_W-1:0] cand;
      int best;
      best = -1;
      if ((m & (m - 1'b1)) == '0) begin
        for (int c = 0; c < CPUS; c++) begin
          if (m[c]) return c;
        end
        return 0;
      end
      cand = m & cpus_up;
      for (int c = 0; c < CPUS; c++) begin
        if (cand[c]) begin
          if (load[c] == '0) return c;
          if (best < 0 || load[c] < load[best]) best = c;
        end
      end
      if (best >= 0) return best;
      for (int c = 0; c < CPUS; c++) begin
        if (cpus_up[c]) return c;
      end
      return 0;
    endfunction

    function grant_t share(status_e st, int s);
      if (count[s] != REFS_MAX) count[s]++;
      return make(st, int'(base_vec) + s, owner[s], count[s], count[s] > overload_above);
    endfunction

    function grant_t serve_request(logic [MASK_W-1:0] m);
      int n;
      int best;
      int c;
      n    = span();
      best = -1;
      if (m == '0) return make(RS_EMPTY_MASK, 0, 0, 0, 1'b0);
      for (int s = 0; s < n; s++) begin
        if (in_use[s] && m[owner[s]]) begin
          if (count[s] < share_below) return share(RS_SHARED, s);
          if (best < 0 || count[s] < count[best]) best = s;
        end
      end
      for (int s = 0; s < n; s++) begin
        if (!in_use[s]) begin
          c = pick_cpu(m);
          if (load[c] != LOAD_MAX) load[c]++;
          in_use[s] = 1'b1;
          count[s]  = 8'd1;
          owner[s]  = CPU_W'(c);
          return make(RS_NEW, int'(base_vec) + s, c, 1, 1'b0);
        end
      end
      if (best >= 0) return share(RS_SHARED_EXH, best);
      return make(RS_EXHAUSTED, 0, 0, 0, 1'b0);
    endfunction

    function int find_slot(logic [VEC_W-1:0] v);
      int off;
      if (v < base_vec) return -1;
      off = int'(v) - int'(base_vec);
      if (off >= span()) return -1;
      if (!in_use[off]) return -1;
      return off;
    endfunction

    function void note_beat(logic [1:0] kind, logic [MASK_W-1:0] m, logic [VEC_W-1:0] v);
      int s;
      case (kind)
        REQ_ALLOC: begin
          due_grants.push_back(serve_request(m));
        end
        REQ_GET: begin
          s = find_slot(v);
          if (s < 0) begin
            due_grants.push_back(make(RS_GET_REFUSED, v, 0, 0, 1'b0));
          end else begin
            if (count[s] != REFS_MAX) count[s]++;
            due_grants.push_back(make(RS_GOT, v, owner[s], count[s], 1'b0));
          end
        end
        REQ_PUT: begin
          s = find_slot(v);
          if (s < 0) begin
            due_grants.push_back(make(RS_BAD_PUT, v, 0, 0, 1'b0));
          end else if (count[s] > 8'd1) begin
            count[s]--;
            due_grants.push_back(make(RS_DROPPED, v, owner[s], count[s], 1'b0));
          end else begin
            count[s]  = '0;
            in_use[s] = 1'b0;
            if (load[owner[s]] != '0) load[owner[s]]--;
            due_grants.push_back(make(RS_FREED, v, owner[s], 0, 1'b0));
          end
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string what, int want, int seen, time now);
      if (want != seen) begin
        $display("%0t ns: %s expected %0d actual %0d", now, what, want, seen);
        errors++;
      end
    endfunction

    function void check_grant(grant_t got, time now);
      grant_t exp;
      if (due_grants.size() == 0) begin
        $display("%0t ns: result beat with nothing outstanding, status %0d vector %0d",
                 now, got.status, got.vec);
        errors++;
        return;
      end
      exp = due_grants.pop_front();
      compare_field("status", exp.status, got.status, now);
      compare_field("result_vector", exp.vec, got.vec, now);
      compare_field("bound_cpu", exp.cpu, got.cpu, now);
      compare_field("ref_count", exp.refs, got.refs, now);
      compare_field("overloaded", exp.ovl, got.ovl, now);
    endfunction

    // Some vector that is live in the current pool window, or the base when none is.
    function logic [VEC_W-1:0] live_vector();
      int picks[$];
      for (int s = 0; s < span(); s++) begin
        if (in_use[s]) picks.push_back(s);
      end
      if (picks.size() == 0) return VEC_W'(base_vec);
      return VEC_W'(int'(base_vec) + picks[$urandom_range(picks.size() - 1)]);
    endfunction
  endclass

endpackage

@@ tb/sv/tb_irq_vector_pool_allocator.sv @@
// The testbench drives request, take and drop beats into the allocator, predicts every
// result beat with the grant tracker and compares the results field by field in order.
// Both handshakes idle at random, and the configuration is reprogrammed between phases
// only after every outstanding result has come back and the block has had time to settle.
module tb_irq_vector_pool_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import ivpa_pkg::*;
  import ivpa_tb_pkg::*;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_ONLINE;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic [1:0]            req_type_i  = REQ_ALLOC;
  logic [MASK_W-1:0]     cpu_sel_i   = '0;
  logic [VEC_W-1:0]      vector_i    = '0;
  logic                  out_stall_i = 1'b0;

  logic              in_stall_o;
  logic              out_valid_o;
  logic [3:0]        status_o;
  logic [VEC_W-1:0]  result_vector_o;
  logic [CPU_W-1:0]  bound_cpu_o;
  logic [REFS_W-1:0] ref_count_o;
  logic              overloaded_o;

  grant_tracker book;

  // While calm is set neither side idles, so beats go back to back.
  bit calm = 1'b0;

  irq_vector_pool_allocator uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .cpu_sel_i      (cpu_sel_i),
    .vector_i       (vector_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .result_vector_o(result_vector_o),
    .bound_cpu_o    (bound_cpu_o),
    .ref_count_o    (ref_count_o),
    .overloaded_o   (overloaded_o)
  );

  always #10 clk_i = ~clk_i;

  // Result side. Outputs are read at the edge, before any update of that edge lands,
  // so a beat is taken exactly when the block sees valid high and stall low. The stall
  // for the next cycle is then chosen at random, or held low while calm is set.
  always @(posedge clk_i) begin : result_sink
    grant_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.status = status_e'(status_o);
      got.vec    = result_vector_o;
      got.cpu    = bound_cpu_o;
      got.refs   = ref_count_o;
      got.ovl    = overloaded_o;
      book.check_grant(got, $time);
    end
    out_stall_i <= !calm && ($urandom_range(99) < 22);
  end

  // Presents one beat, with random idle cycles before it, and returns at the edge that
  // accepts it. Valid is left high so that a following beat can go out without a gap;
  // the caller lowers it in the same step if nothing follows.
  task automatic send_beat(logic [1:0] kind, logic [MASK_W-1:0] m, logic [VEC_W-1:0] v);
    while (!calm && $urandom_range(99) < 22) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    cpu_sel_i  <= m;
    vector_i   <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    book.note_beat(kind, m, v);
  endtask

  // Stops sending and waits for every owed result. An ignored beat never takes the block
  // out of idle, so by then no beat is still in flight; the extra cycles only let it settle.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (book.pending() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  // Writes all five registers, one per cycle, once the block is idle.
  task automatic program_regs(logic [15:0] up, logic [10:0] base, logic [6:0] size,
                              logic [7:0] lo, logic [7:0] hi);
    cfg_idx_e        idx  [5];
    logic [15:0]     vals [5];
    idx  = '{CFG_ONLINE, CFG_POOL_BASE, CFG_POOL_SIZE, CFG_MIN_REFS, CFG_MAX_REFS};
    vals = '{up, 16'(base), 16'(size), 16'(lo), 16'(hi)};
    settle();
    for (int i = 0; i < 5; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
      book.write_reg(idx[i], vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Masks lean toward the interesting shapes: single CPUs, the full set, only online
  // CPUs, only offline CPUs, and now and then an empty mask.
  function automatic logic [MASK_W-1:0] pick_mask();
    case ($urandom_range(9))
      0: return MASK_W'(1) << $urandom_range(15);
      1: return (MASK_W'(1) << $urandom_range(15)) | (MASK_W'(1) << $urandom_range(15));
      2: return 16'hFFFF;
      3: return book.cpus_up & MASK_W'($urandom);
      4: return ~book.cpus_up & MASK_W'($urandom);
      5: return ($urandom_range(19) == 0) ? '0 : MASK_W'($urandom);
      default: return MASK_W'($urandom);
    endcase
  endfunction

  // Mostly a live vector; otherwise just outside the window on either side, or anything.
  function automatic logic [VEC_W-1:0] pick_vector();
    case ($urandom_range(19))
      0: return VEC_W'(book.base_vec) - 1'b1;
      1: return VEC_W'(int'(book.base_vec) + book.span());
      2: return VEC_W'($urandom);
      default: return book.live_vector();
    endcase
  endfunction

  // A run of random beats. With focus set, take and drop aim at a live vector, or at the base when none is live.
  task automatic random_beats(int count, int pct_req, int pct_get, bit focus);
    int roll;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (roll < pct_req) begin
        send_beat(REQ_ALLOC, pick_mask(), VEC_W'($urandom));
      end else if (roll < pct_req + pct_get) begin
        send_beat(REQ_GET, MASK_W'($urandom), focus ? book.live_vector() : pick_vector());
      end else if (roll < 96) begin
        send_beat(REQ_PUT, MASK_W'($urandom), focus ? book.live_vector() : pick_vector());
      end else begin
        send_beat(REQ_IGNORED, MASK_W'($urandom), VEC_W'($urandom));
      end
    end
  endtask

  initial begin
    book = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed beats on the reset configuration. An empty mask, then take and drop on a
    // free slot, must all be refused.
    send_beat(REQ_ALLOC, 16'h0000, 12'd0);
    send_beat(REQ_GET,   16'hFFFF, 12'd0);
    send_beat(REQ_PUT,   16'hFFFF, 12'd0);
    // Single-CPU masks bind to the lowest and the highest CPU.
    send_beat(REQ_ALLOC, 16'h0001, 12'd0);
    send_beat(REQ_ALLOC, 16'h8000, 12'hFFF);
    // Both vectors sit below the minimum count, so a full mask shares each in turn.
    send_beat(REQ_ALLOC, 16'hFFFF, 12'd0);
    send_beat(REQ_ALLOC, 16'hFFFF, 12'd0);
    // A wider mask with no match gets a fresh slot on its first idle CPU.
    send_beat(REQ_ALLOC, 16'h00F0, 12'd0);
    send_beat(REQ_GET,   16'h0000, 12'd2);
    send_beat(REQ_PUT,   16'h0000, 12'd2);
    send_beat(REQ_PUT,   16'h0000, 12'd2);
    send_beat(REQ_PUT,   16'h0000, 12'd2);
    // The ignored type gives no result at all.
    send_beat(REQ_IGNORED, 16'hFFFF, 12'd0);
    // The top of the vector range and the first vector past the pool.
    send_beat(REQ_GET,   16'h0000, 12'hFFF);
    send_beat(REQ_GET,   16'h0000, 12'd64);
    send_beat(REQ_ALLOC, 16'h00F0, 12'd0);

    random_beats(25, 40, 30, 1'b0);
    // Hold off until the block has drained completely, then resume.
    settle();
    calm = 1'b1;
    random_beats(30, 40, 30, 1'b0);
    calm = 1'b0;

    // A tiny pool at the top base: it fills at once, and shares report overload early.
    // Slots beyond the shrunken pool stay allocated but become unreachable.
    program_regs(16'hA5C3, 11'd2047, 7'd4, 8'd0, 8'd3);
    random_beats(40, 45, 25, 1'b0);

    // One slot that every request whose mask holds its CPU shares, with take beats aimed at it,
    // so that the reference count climbs toward its ceiling.
    program_regs(16'hFFFF, 11'd100, 7'd1, 8'd255, 8'd0);
    random_beats(290, 10, 86, 1'b1);

    // No CPU online, and a pool size beyond the slot memory. A multi-CPU mask falls back
    // to CPU zero, and a single offline CPU is still taken as given.
    program_regs(16'h0000, 11'd0, 7'd127, 8'd1, 8'd255);
    send_beat(REQ_ALLOC, 16'h0006, 12'd0);
    send_beat(REQ_ALLOC, 16'h0400, 12'd0);
    random_beats(40, 45, 25, 1'b0);

    // An empty pool: every request ends exhausted or with an empty mask.
    program_regs(16'h0F0F, 11'd1000, 7'd0, 8'd3, 8'd5);
    random_beats(15, 50, 25, 1'b0);

    program_regs(MASK_W'($urandom), 11'($urandom), 7'($urandom_range(64, 1)),
                 8'($urandom), 8'($urandom));
    random_beats(40, 40, 30, 1'b0);

    settle();
    if (book.errors == 0 && book.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

@@ irq_vector_pool_allocator.f @@
rtl/core/ivpa_pkg.sv
rtl/core/ivpa_ctrl.sv
rtl/core/ivpa_dpath.sv
rtl/core/irq_vector_pool_allocator.sv
tb/sv/ivpa_tb_pkg.sv
tb/sv/tb_irq_vector_pool_allocator.sv
